// File: sv/vgm_command_stream_parser_assert.svh
// assertion macros for the vgm command stream parser
`ifndef VGM_COMMAND_STREAM_PARSER_ASSERT_SVH
`define VGM_COMMAND_STREAM_PARSER_ASSERT_SVH
// property must hold in the cycle after the antecedent
`define VGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// property must hold in the same cycle
`define VGM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// File: sv/vgm_pkg.sv
// shared types and constants for the vgm command stream parser
package vgm_pkg;
   localparam int PcmDepth = 16384;
   localparam int PcmAw = $clog2(PcmDepth);
   localparam int AddrBits = 24;

   localparam logic [2:0] KindPsg = 3'd0;
   localparam logic [2:0] KindFm = 3'd1;
   localparam logic [2:0] KindWait = 3'd2;
   localparam logic [2:0] KindDacMem = 3'd3;
   localparam logic [2:0] KindRestart = 3'd4;

   // stream command bytes
   localparam logic [7:0] CmdPsgDual = 8'h4F;
   localparam logic [7:0] CmdPsg = 8'h50;
   localparam logic [7:0] CmdFmPort0 = 8'h52;
   localparam logic [7:0] CmdFmPort1 = 8'h53;
   localparam logic [7:0] CmdWait = 8'h61;
   localparam logic [7:0] CmdWaitNtsc = 8'h62;
   localparam logic [7:0] CmdWaitPal = 8'h63;
   localparam logic [7:0] CmdEnd = 8'h66;
   localparam logic [7:0] CmdBlock = 8'h67;
   localparam logic [7:0] CmdShortWait = 8'h70;
   localparam logic [7:0] CmdDac = 8'h80;
   localparam logic [7:0] CmdSeek = 8'hE0;

   localparam logic [7:0] DacReg = 8'h2A;
   localparam logic [7:0] PsgLatch = 8'h06;
   localparam logic [15:0] NtscSamples = 16'd735;
   localparam logic [15:0] PalSamples = 16'd882;

   typedef enum logic [3:0] {
      PH_IDLE, PH_PSG, PH_FM_REG, PH_FM_DATA, PH_WAIT, PH_BLK_MARK,
      PH_BLK_TYPE, PH_BLK_LEN, PH_BLK_STORE, PH_BLK_SKIP, PH_SEEK
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        fm_port;
      logic [7:0]  reg_addr;
      logic [7:0]  write_value;
      logic [15:0] wait_samples;
      logic [23:0] mem_addr;
      logic        last_result;
   } rsp_type;
endpackage

// File: sv/vgm_req_if.sv
// stream byte channel
interface vgm_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

// File: sv/vgm_rsp_if.sv
// result channel
interface vgm_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic        fm_port;
   logic [7:0]  reg_addr;
   logic [7:0]  write_value;
   logic [15:0] wait_samples;
   logic [23:0] mem_addr;
   logic        last_result;
   modport source (output valid, output kind, output fm_port, output reg_addr,
      output write_value, output wait_samples, output mem_addr, output last_result,
      input ready);
   modport sink (input valid, input kind, input fm_port, input reg_addr,
      input write_value, input wait_samples, input mem_addr, input last_result,
      output ready);
endinterface

// File: sv/vgm_ram.sv
// generic ram with one write port and one read port, registered read
module vgm_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/vgm_command_stream_parser.sv
// vgm command stream parser top level
// Takes one stream byte per cycle and emits psg/fm writes, waits, dac writes and
// restarts. A byte is accepted every cycle while the three-entry result queue has
// room; a psg 0x4F data byte produces two results and, as the queue drains one per
// cycle, the input stalls behind it.
// The pcm store is a 16384-byte ram with one write and one read port; a dac read
// issues in the cycle of the command byte and its data lands in the result stage
// behind it, so the rate stays one byte per cycle while the queue has room.
module vgm_command_stream_parser (
   input logic        clock,
   input logic        reset,
   input logic        csr_we,
   input logic [7:0]  csr_wdata,
   vgm_req_if.sink    req,
   vgm_rsp_if.source  rsp
);
   localparam int Aw = vgm_pkg::PcmAw;
   localparam int Ab = vgm_pkg::AddrBits;

   logic [7:0] start_ff;
   vgm_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  regh_ff, regh_in;
   logic [Ab-1:0] pos_ff, pos_in;
   logic [31:0] blen_ff, blen_in, brem_ff, brem_in;
   logic        loaded_ff, loaded_in;
   logic [31:0] pidx_ff, pidx_in;
   logic [Ab-1:0] pstart_ff, pstart_in, pext_ff, pext_in;

   // stage between parse and queue: up to two results, one may need ram data
   logic           s_vld_ff, s_vld_in;
   logic           s_two_ff, s_two_in;
   logic           s_ram_ff, s_ram_in;
   vgm_pkg::rsp_type s_r0_ff, s_r0_in, s_r1_ff, s_r1_in;

   logic        wr_en;
   logic [Aw-1:0] wr_addr, rd_addr;
   logic [7:0]  rd_data;

   vgm_ram #(.Width(8), .Depth(vgm_pkg::PcmDepth)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data(req.stream_byte), .rd_addr, .rd_data);

   // output queue of up to three entries
   vgm_pkg::rsp_type q_ff [3];
   logic [1:0] qn_ff;
   logic       take, acc;
   vgm_pkg::rsp_type r0f;
   logic [1:0] add, pop, after;

   assign take = req.valid & req.ready;
   assign pop = (rsp.valid & rsp.ready) ? 2'd1 : 2'd0;
   assign add = s_vld_ff ? (s_two_ff ? 2'd2 : 2'd1) : 2'd0;
   assign after = qn_ff - pop + add;
   // stage may hold 2 and queue 3: accept while what remains leaves room
   assign req.ready = (after <= 2'd1) && !reset;
   assign acc = take;

   always_comb begin
      r0f = s_r0_ff;
      if (s_ram_ff) r0f.write_value = rd_data;
   end

   assign rsp.valid = qn_ff != 2'd0;
   assign rsp.kind = q_ff[0].kind;
   assign rsp.fm_port = q_ff[0].fm_port;
   assign rsp.reg_addr = q_ff[0].reg_addr;
   assign rsp.write_value = q_ff[0].write_value;
   assign rsp.wait_samples = q_ff[0].wait_samples;
   assign rsp.mem_addr = q_ff[0].mem_addr;
   assign rsp.last_result = q_ff[0].last_result;

   always_ff @(posedge clock) begin
      vgm_pkg::rsp_type t [5];
      t[0] = q_ff[0]; t[1] = q_ff[1]; t[2] = q_ff[2]; t[3] = r0f; t[4] = s_r1_ff;
      if (reset) begin
         qn_ff <= 2'd0;
      end else begin
         qn_ff <= after;
         for (int i = 0; i < 3; i++) begin
            logic [2:0] j;
            j = 3'(i) + 3'(pop);
            if (j < 3'(qn_ff)) q_ff[i] <= t[j[1:0]];
            else if (j - 3'(qn_ff) == 3'd0) q_ff[i] <= r0f;
            else q_ff[i] <= s_r1_ff;
         end
      end
   end

   function automatic vgm_pkg::rsp_type mk(logic [2:0] k, logic p, logic [7:0] r,
         logic [7:0] v, logic [15:0] w, logic [23:0] a, logic l);
      vgm_pkg::rsp_type x;
      x.kind = k; x.fm_port = p; x.reg_addr = r; x.write_value = v;
      x.wait_samples = w; x.mem_addr = a; x.last_result = l;
      return x;
   endfunction

   logic [7:0]  b;
   logic [31:0] accn;
   logic [2:0]  cntn;
   logic [31:0] at;
   assign b = req.stream_byte;

   always_comb begin
      phase_in = phase_ff; cmd_in = cmd_ff; cnt_in = cnt_ff; acc_in = acc_ff;
      regh_in = regh_ff; pos_in = pos_ff; blen_in = blen_ff; brem_in = brem_ff;
      loaded_in = loaded_ff; pidx_in = pidx_ff; pstart_in = pstart_ff;
      pext_in = pext_ff;
      s_vld_in = 1'b0; s_two_in = 1'b0; s_ram_in = 1'b0;
      s_r0_in = s_r0_ff; s_r1_in = s_r1_ff;
      wr_en = 1'b0; wr_addr = '0; rd_addr = pidx_ff[Aw-1:0];
      accn = acc_ff | (32'(b) << {cnt_ff[1:0], 3'b000});
      cntn = cnt_ff + 3'd1;
      at = blen_ff - brem_ff;
      if (acc) begin
         pos_in = pos_ff + 1'b1;
         case (phase_ff)
            vgm_pkg::PH_IDLE: begin
               if (b == vgm_pkg::CmdPsgDual || b == vgm_pkg::CmdPsg) begin
                  cmd_in = b; phase_in = vgm_pkg::PH_PSG;
               end else if (b == vgm_pkg::CmdFmPort0 || b == vgm_pkg::CmdFmPort1) begin
                  cmd_in = b; phase_in = vgm_pkg::PH_FM_REG;
               end else if (b == vgm_pkg::CmdWait) begin
                  cnt_in = '0; acc_in = '0; phase_in = vgm_pkg::PH_WAIT;
               end else if (b == vgm_pkg::CmdWaitNtsc || b == vgm_pkg::CmdWaitPal) begin
                  s_vld_in = 1'b1;
                  s_r0_in = mk(vgm_pkg::KindWait, 1'b0, '0, '0,
                     (b == vgm_pkg::CmdWaitNtsc) ? vgm_pkg::NtscSamples
                                                 : vgm_pkg::PalSamples, '0, 1'b1);
               end else if (b == vgm_pkg::CmdBlock) begin
                  phase_in = vgm_pkg::PH_BLK_MARK;
               end else if (b[7:4] == vgm_pkg::CmdShortWait[7:4]) begin
                  s_vld_in = 1'b1;
                  s_r0_in = mk(vgm_pkg::KindWait, 1'b0, '0, '0, 16'(b[3:0]) + 16'd1,
                     '0, 1'b1);
               end else if (b[7:4] == vgm_pkg::CmdDac[7:4]) begin
                  s_vld_in = 1'b1;
                  if (loaded_ff) begin
                     s_ram_in = pidx_ff < 32'(vgm_pkg::PcmDepth);
                     pidx_in = pidx_ff + 32'd1;
                     s_r0_in = mk(vgm_pkg::KindFm, 1'b0, vgm_pkg::DacReg, '0,
                        16'(b[3:0]), '0, 1'b1);
                  end else begin
                     pext_in = pext_ff + 1'b1;
                     s_r0_in = mk(vgm_pkg::KindDacMem, 1'b0, vgm_pkg::DacReg, '0,
                        16'(b[3:0]), 24'(pext_ff + 1'b1), 1'b1);
                  end
               end else if (b == vgm_pkg::CmdSeek) begin
                  cnt_in = '0; acc_in = '0; phase_in = vgm_pkg::PH_SEEK;
               end else if (b == vgm_pkg::CmdEnd) begin
                  pext_in = '0; pidx_in = '0; blen_in = '0; brem_in = '0;
                  loaded_in = 1'b0; pos_in = Ab'(start_ff);
                  s_vld_in = 1'b1;
                  s_r0_in = mk(vgm_pkg::KindRestart, 1'b0, '0, '0, '0, 24'(start_ff),
                     1'b1);
               end
            end
            vgm_pkg::PH_PSG: begin
               s_vld_in = 1'b1;
               phase_in = vgm_pkg::PH_IDLE;
               if (cmd_ff == vgm_pkg::CmdPsgDual) begin
                  s_two_in = 1'b1;
                  s_r0_in = mk(vgm_pkg::KindPsg, 1'b0, '0, vgm_pkg::PsgLatch, '0, '0,
                     1'b0);
                  s_r1_in = mk(vgm_pkg::KindPsg, 1'b0, '0, b, '0, '0, 1'b1);
               end else begin
                  s_r0_in = mk(vgm_pkg::KindPsg, 1'b0, '0, b, '0, '0, 1'b1);
               end
            end
            vgm_pkg::PH_FM_REG: begin
               regh_in = b; phase_in = vgm_pkg::PH_FM_DATA;
            end
            vgm_pkg::PH_FM_DATA: begin
               s_vld_in = 1'b1;
               s_r0_in = mk(vgm_pkg::KindFm, cmd_ff == vgm_pkg::CmdFmPort1, regh_ff, b,
                  '0, '0, 1'b1);
               phase_in = vgm_pkg::PH_IDLE;
            end
            vgm_pkg::PH_WAIT: begin
               acc_in = accn; cnt_in = cntn;
               if (cntn >= 3'd2) begin
                  s_vld_in = 1'b1;
                  s_r0_in = mk(vgm_pkg::KindWait, 1'b0, '0, '0, accn[15:0], '0, 1'b1);
                  phase_in = vgm_pkg::PH_IDLE;
               end
            end
            vgm_pkg::PH_BLK_MARK: phase_in = vgm_pkg::PH_BLK_TYPE;
            vgm_pkg::PH_BLK_TYPE: begin
               cnt_in = '0; acc_in = '0; phase_in = vgm_pkg::PH_BLK_LEN;
            end
            vgm_pkg::PH_BLK_LEN: begin
               acc_in = accn; cnt_in = cntn;
               if (cntn >= 3'd4) begin
                  blen_in = accn; brem_in = accn;
                  if (accn != 32'd0 && accn <= 32'(vgm_pkg::PcmDepth) && !loaded_ff) begin
                     phase_in = vgm_pkg::PH_BLK_STORE;
                  end else begin
                     if (!loaded_ff) begin
                        pstart_in = pos_ff; pext_in = pos_ff;
                     end
                     phase_in = (accn == 32'd0) ? vgm_pkg::PH_IDLE : vgm_pkg::PH_BLK_SKIP;
                  end
               end
            end
            vgm_pkg::PH_BLK_STORE: begin
               wr_en = at < 32'(vgm_pkg::PcmDepth);
               wr_addr = at[Aw-1:0];
               brem_in = brem_ff - 32'd1;
               if (brem_ff == 32'd1) begin
                  pidx_in = '0; loaded_in = 1'b1; phase_in = vgm_pkg::PH_IDLE;
               end
            end
            vgm_pkg::PH_BLK_SKIP: begin
               brem_in = brem_ff - 32'd1;
               if (brem_ff == 32'd1) phase_in = vgm_pkg::PH_IDLE;
            end
            vgm_pkg::PH_SEEK: begin
               acc_in = accn; cnt_in = cntn;
               if (cntn >= 3'd4) begin
                  if (loaded_ff) pidx_in = accn;
                  else pext_in = pstart_ff + accn[Ab-1:0];
                  phase_in = vgm_pkg::PH_IDLE;
               end
            end
            default: phase_in = vgm_pkg::PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 8'd64;
         phase_ff <= vgm_pkg::PH_IDLE;
         cmd_ff <= '0; cnt_ff <= '0; acc_ff <= '0; regh_ff <= '0;
         pos_ff <= Ab'(64); blen_ff <= '0; brem_ff <= '0; loaded_ff <= 1'b0;
         pidx_ff <= '0; pstart_ff <= '0; pext_ff <= '0;
         s_vld_ff <= 1'b0; s_two_ff <= 1'b0; s_ram_ff <= 1'b0;
      end else begin
         if (csr_we) start_ff <= csr_wdata;
         phase_ff <= phase_in; cmd_ff <= cmd_in; cnt_ff <= cnt_in; acc_ff <= acc_in;
         regh_ff <= regh_in;
         pos_ff <= pos_in;
         blen_ff <= blen_in; brem_ff <= brem_in; loaded_ff <= loaded_in;
         pidx_ff <= pidx_in; pstart_ff <= pstart_in; pext_ff <= pext_in;
         s_vld_ff <= s_vld_in; s_two_ff <= s_two_in; s_ram_ff <= s_ram_in;
      end
      s_r0_ff <= s_r0_in; s_r1_ff <= s_r1_in;
   end
endmodule

// File: sv/vgm_checker.sv
// port-level checker for the vgm command stream parser
`include "vgm_command_stream_parser_assert.svh"
module vgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [7:0]  rsp_reg_addr,
   input logic        rsp_last_result
);
   `VGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `VGM_ASSERT_NOW(a_kind_range, clock, reset, rsp_valid,
      rsp_kind <= vgm_pkg::KindRestart, "bad kind")
   `VGM_ASSERT_NOW(a_dac_reg, clock, reset, rsp_valid && rsp_kind == vgm_pkg::KindDacMem,
      rsp_reg_addr == vgm_pkg::DacReg && rsp_last_result, "bad dac result")
   `VGM_ASSERT_NOW(a_not_last_psg, clock, reset, rsp_valid && !rsp_last_result,
      rsp_kind == vgm_pkg::KindPsg, "only psg pairs split")
   `VGM_ASSERT_NOW(a_req_ready_known, clock, reset, req_valid,
      !$isunknown(req_ready), "req ready unknown")
endmodule

bind vgm_command_stream_parser vgm_checker u_vgm_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.kind),
   .rsp_reg_addr(rsp.reg_addr), .rsp_last_result(rsp.last_result));
